@@ hw/rtl/drt_pkg.sv @@
// Shared types and constants for the divider and reload timer.
// Used by every module of the block; depends on nothing.
package drt_pkg;

  localparam int unsigned DRT_DIVIDER_TICKS = 61;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned SEL_W  = 2;
  localparam int unsigned BYTE_W = 8;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Register selects
  localparam logic [SEL_W-1:0] REG_DIV     = 2'd0;
  localparam logic [SEL_W-1:0] REG_COUNT   = 2'd1;
  localparam logic [SEL_W-1:0] REG_RELOAD  = 2'd2;
  localparam logic [SEL_W-1:0] REG_CONTROL = 2'd3;

  localparam int unsigned TIMER_EN_BIT = 2;
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEL_W-1:0]  reg_select;
    logic [BYTE_W-1:0] write_data;
  } drt_item_t;

  typedef struct packed {
    logic              timer_irq;
    logic [BYTE_W-1:0] read_data;
  } drt_result_t;

  // Timer prescaler limit picked by control bits 1:0
  function automatic logic [BYTE_W-1:0] timer_limit(input logic [1:0] rate);
    logic [BYTE_W-1:0] lim;
    case (rate)
      2'd0:    lim = 8'd244;
      2'd1:    lim = 8'd4;
      2'd2:    lim = 8'd15;
      default: lim = 8'd61;
    endcase
    return lim;
  endfunction

endpackage

@@ hw/rtl/drt_in_stage.sv @@
// Input register of the timer: captures one request and holds it until
// the register stage takes it. Depends on drt_pkg.
module drt_in_stage
  import drt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  drt_item_t in_item,
  output logic      item_valid,
  input  logic      item_take,
  output drt_item_t item
);

  logic      valid_r, valid_nxt;
  drt_item_t item_r;
  logic      load;

  assign in_ready  = !valid_r || item_take;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (item_take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ hw/rtl/drt_regs.sv @@
// Timer register file and tick logic: divider, counter, reload, control and
// both prescalers, updated once per request taken. Depends on drt_pkg.
module drt_regs
  import drt_pkg::*;
#(
  parameter int unsigned DIVIDER_TICKS = DRT_DIVIDER_TICKS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  drt_item_t   item,
  output drt_result_t result
);

  localparam logic [BYTE_W-1:0] DivLimit = BYTE_W'(DIVIDER_TICKS);

  logic [BYTE_W-1:0] div_pre_r, div_pre_nxt;
  logic [BYTE_W-1:0] div_r, div_nxt;
  logic [BYTE_W-1:0] tim_pre_r, tim_pre_nxt;
  logic [BYTE_W-1:0] count_r, count_nxt;
  logic [BYTE_W-1:0] reload_r, reload_nxt;
  logic [BYTE_W-1:0] control_r, control_nxt;

  logic              is_tick;
  logic [BYTE_W-1:0] div_pre_inc;
  logic [BYTE_W-1:0] tim_pre_inc;
  logic              tim_hit;
  logic              irq;

  assign is_tick     = fire && (item.kind == KIND_TICK);
  assign div_pre_inc = div_pre_r + 8'd1;
  assign tim_pre_inc = tim_pre_r + 8'd1;
  assign tim_hit     = control_r[TIMER_EN_BIT] && (tim_pre_inc >= timer_limit(control_r[1:0]));
  assign irq         = is_tick && tim_hit && (count_r == BYTE_MAX);

  always_comb begin
    div_pre_nxt = div_pre_r;
    div_nxt     = div_r;
    tim_pre_nxt = tim_pre_r;
    count_nxt   = count_r;
    reload_nxt  = reload_r;
    control_nxt = control_r;
    if (is_tick) begin
      if (div_pre_inc == DivLimit) begin
        div_pre_nxt = '0;
        div_nxt     = div_r + 8'd1;
      end else begin
        div_pre_nxt = div_pre_inc;
      end
      if (control_r[TIMER_EN_BIT]) begin
        if (tim_hit) begin
          tim_pre_nxt = '0;
          // wrap from the top loads the reload byte
          count_nxt   = (count_r == BYTE_MAX) ? reload_r : count_r + 8'd1;
        end else begin
          tim_pre_nxt = tim_pre_inc;
        end
      end
    end else if (fire && (item.kind == KIND_WRITE)) begin
      unique case (item.reg_select)
        REG_DIV:     div_nxt     = item.write_data;
        REG_COUNT:   count_nxt   = item.write_data;
        REG_RELOAD:  reload_nxt  = item.write_data;
        REG_CONTROL: control_nxt = item.write_data;
        default:     control_nxt = item.write_data;
      endcase
    end
  end

  always_comb begin
    result.timer_irq = irq;
    result.read_data = '0;
    if (item.kind == KIND_READ) begin
      unique case (item.reg_select)
        REG_DIV:     result.read_data = div_r;
        REG_COUNT:   result.read_data = count_r;
        REG_RELOAD:  result.read_data = reload_r;
        REG_CONTROL: result.read_data = control_r;
        default:     result.read_data = control_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_pre_r <= '0;
      div_r     <= '0;
      tim_pre_r <= '0;
      count_r   <= '0;
      reload_r  <= '0;
      control_r <= '0;
    end else begin
      div_pre_r <= div_pre_nxt;
      div_r     <= div_nxt;
      tim_pre_r <= tim_pre_nxt;
      count_r   <= count_nxt;
      reload_r  <= reload_nxt;
      control_r <= control_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_irq_needs_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    irq |-> (item.kind == KIND_TICK) && (count_r == BYTE_MAX) && control_r[TIMER_EN_BIT])
    else $error("timer irq without counter wrap");

  a_reload_on_irq: assert property (@(posedge clk) disable iff (!rst_n)
    irq |=> count_r == $past(reload_r))
    else $error("counter not reloaded on overflow");

  a_div_pre_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    div_pre_r != DivLimit)
    else $error("divider prescaler held its limit");
`endif

endmodule

@@ hw/rtl/drt_out_stage.sv @@
// Result register of the timer: holds one result until the sink takes it.
// Depends on drt_pkg.
module drt_out_stage
  import drt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  output logic        res_ready,
  input  drt_result_t res,
  output logic        out_valid,
  input  logic        out_ready,
  output drt_result_t out_res
);

  logic        valid_r, valid_nxt;
  drt_result_t res_r;
  logic        load;

  assign res_ready = !valid_r || out_ready;
  assign load      = res_valid && res_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

@@ hw/rtl/divider_and_reload_timer_core.sv @@
// Top level of the divider and reload timer; instantiates drt_in_stage,
// drt_regs and drt_out_stage, types from drt_pkg.
//
// Each request (a tick, a register write or a register read) gives exactly
// one result. One request is taken every clock cycle while the sink keeps
// out_tready high. A request is accepted into the input register. Once the
// result register can take it, it passes through the register update into
// the result register, whose output is on out_tdata until the sink takes it.
// When a result waits at the output, the request behind it stays in the
// input register. One more request can still be accepted until that register
// fills. After that, in_tready stays low until the sink takes the result.
// The divider advances every DIVIDER_TICKS ticks. The counter advances at
// the rate picked by control bits 1:0 while control bit 2 is set. A wrap
// from 255 reloads the counter and sets timer_irq for that tick.
module divider_and_reload_timer_core
  import drt_pkg::*;
#(
  parameter int unsigned DIVIDER_TICKS = DRT_DIVIDER_TICKS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] reg_select, [9:2] write_data, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] read_data, [8] timer_irq, rest zero
);

  drt_item_t   in_item;
  drt_item_t   item;
  logic        item_valid;
  logic        fire;
  logic        res_ready;
  drt_result_t res;
  drt_result_t out_res;

  assign in_item.kind       = in_tuser;
  assign in_item.reg_select = in_tdata[1:0];
  assign in_item.write_data = in_tdata[9:2];

  assign fire = item_valid && res_ready;

  drt_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .item_valid(item_valid),
    .item_take (fire),
    .item      (item)
  );

  drt_regs #(
    .DIVIDER_TICKS(DIVIDER_TICKS)
  ) u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .result(res)
  );

  drt_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(item_valid),
    .res_ready(res_ready),
    .res      (res),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  assign out_tdata = {7'd0, out_res.timer_irq, out_res.read_data};

endmodule

@@ bench/divider_and_reload_timer_core_tb.sv @@
// Self-checking bench for divider_and_reload_timer_core. It tracks the timer
// state on every accepted request and compares each result in order.
// Depends on drt_pkg and the core RTL.
module divider_and_reload_timer_core_tb;
  import drt_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 412;
  localparam int LONG_HOLD_CYCLES = 300;

  class drt_result_tracker;
    logic [BYTE_W-1:0] div_pre;
    logic [BYTE_W-1:0] div_val;
    logic [BYTE_W-1:0] tmr_pre;
    logic [BYTE_W-1:0] count_val;
    logic [BYTE_W-1:0] reload_val;
    logic [BYTE_W-1:0] ctrl_val;
    logic [BYTE_W-1:0] rate_limit [4];
    drt_result_t pending_results [$];
    int mismatches;

    function new();
      rate_limit = '{8'd244, 8'd4, 8'd15, 8'd61};
      div_pre = '0;
      div_val = '0;
      tmr_pre = '0;
      count_val = '0;
      reload_val = '0;
      ctrl_val = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    // Advance the timer state for one accepted request and queue its result.
    function void note_request(logic [KIND_W-1:0] kind, logic [SEL_W-1:0] sel,
                               logic [BYTE_W-1:0] data);
      drt_result_t res;
      res = '0;
      case (kind)
        KIND_TICK: begin
          div_pre = div_pre + 8'd1;
          if (div_pre == 8'(DRT_DIVIDER_TICKS)) begin
            div_val = div_val + 8'd1;
            div_pre = '0;
          end
          // hold the timer prescaler while the enable bit is clear
          if (ctrl_val[TIMER_EN_BIT]) begin
            tmr_pre = tmr_pre + 8'd1;
            if (tmr_pre >= rate_limit[ctrl_val[1:0]]) begin
              tmr_pre = '0;
              if (count_val == BYTE_MAX) begin
                count_val = reload_val;
                res.timer_irq = 1'b1;
              end else begin
                count_val = count_val + 8'd1;
              end
            end
          end
        end
        KIND_WRITE: begin
          case (sel)
            REG_DIV:    div_val = data;
            REG_COUNT:  count_val = data;
            REG_RELOAD: reload_val = data;
            default:    ctrl_val = data;
          endcase
        end
        KIND_READ: begin
          case (sel)
            REG_DIV:    res.read_data = div_val;
            REG_COUNT:  res.read_data = count_val;
            REG_RELOAD: res.read_data = reload_val;
            default:    res.read_data = ctrl_val;
          endcase
        end
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [15:0] word);
      drt_result_t want;
      if (pending_results.size() == 0) begin
        flag($sformatf("result %h with no request waiting", word));
        return;
      end
      want = pending_results.pop_front();
      if (word[7:0] !== want.read_data)
        flag($sformatf("read_data expected %h got %h", want.read_data, word[7:0]));
      if (word[8] !== want.timer_irq)
        flag($sformatf("timer_irq expected %b got %b", want.timer_irq, word[8]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // [1:0] reg_select, [9:2] write_data, rest zero
  logic [1:0]  in_tuser = '0;    // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [7:0] read_data, [8] timer_irq, rest zero

  int idle_pct = 0;
  int stall_pct = 0;
  bit long_hold_req = 1'b0;
  int hold_left = 0;
  int phase_idle [4] = '{0, 67, 0, 11};
  int phase_stall [4] = '{0, 0, 67, 11};

  drt_result_tracker tracker = new();

  divider_and_reload_timer_core dut (
    .clk,
    .rst_n,
    .in_tvalid,
    .in_tready,
    .in_tdata,
    .in_tuser,
    .out_tvalid,
    .out_tready,
    .out_tdata
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      tracker.note_request(in_tuser, in_tdata[1:0], in_tdata[9:2]);
    if (rst_n && out_tvalid && out_tready)
      tracker.check_result(out_tdata);
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (long_hold_req) begin
      out_tready <= 1'b0;
      hold_left = LONG_HOLD_CYCLES;
      long_hold_req = 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [SEL_W-1:0] sel,
                              input logic [BYTE_W-1:0] data);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {6'b0, data, sel};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int sent;
    int run_len;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] ctrl;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(KIND_READ, REG_DIV, 8'h00);
    send_request(KIND_READ, REG_CONTROL, 8'hFF);
    send_request(KIND_UNUSED, REG_CONTROL, 8'hFF);
    send_request(KIND_WRITE, REG_RELOAD, 8'hFF);
    send_request(KIND_WRITE, REG_COUNT, 8'hFE);
    // enable at the fastest rate, with every other control bit set too
    send_request(KIND_WRITE, REG_CONTROL, 8'hFD);
    repeat (8) send_request(KIND_TICK, REG_DIV, 8'h00);
    send_request(KIND_READ, REG_COUNT, 8'h00);
    send_request(KIND_WRITE, REG_CONTROL, 8'h06);
    repeat (5) send_request(KIND_TICK, REG_RELOAD, 8'hFF);
    // drop the limit below the running prescaler: fires on the next tick
    send_request(KIND_WRITE, REG_CONTROL, 8'h05);
    send_request(KIND_TICK, REG_COUNT, 8'h00);
    send_request(KIND_WRITE, REG_CONTROL, 8'h00);
    send_request(KIND_TICK, REG_CONTROL, 8'hFF);
    send_request(KIND_WRITE, REG_DIV, 8'hFF);
    send_request(KIND_READ, REG_DIV, 8'h00);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 0) long_hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 75) begin
          // maybe set up a counter near wrap, then write control and run a burst of mostly ticks
          if ($urandom_range(1)) begin
            send_request(KIND_WRITE, REG_COUNT, 8'($urandom_range(240, 255)));
            sent++;
          end
          if ($urandom_range(3) == 0) begin
            send_request(KIND_WRITE, REG_RELOAD, 8'($urandom));
            sent++;
          end
          ctrl = 8'($urandom);
          if ($urandom_range(9) != 0) ctrl[TIMER_EN_BIT] = 1'b1;
          if ($urandom_range(1)) ctrl[1:0] = 2'd1;
          send_request(KIND_WRITE, REG_CONTROL, ctrl);
          sent++;
          run_len = $urandom_range(5, 60);
          repeat (run_len) begin
            if ($urandom_range(9) == 0)
              send_request(KIND_READ, SEL_W'($urandom), 8'($urandom));
            else
              send_request(KIND_TICK, SEL_W'($urandom), 8'($urandom));
            sent++;
          end
        end else begin
          kind = KIND_W'($urandom);
          send_request(kind, SEL_W'($urandom), 8'($urandom));
          if (kind != KIND_UNUSED) sent++;
        end
      end
      drain_results();
    end

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
